FILE: design/mtl_pkg.sv
// Shared types and constants for the Morton index deswizzle block.
// No dependencies.
package mtl_pkg;

  localparam int unsigned IDX_W  = 28;
  localparam int unsigned LIN_W  = 28;
  localparam int unsigned CRD_W  = 14;
  localparam int unsigned REG_W  = 15;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DIM_BITS_DEFAULT = 14;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
  } mtl_item_t;

  typedef struct packed {
    logic push;
    logic full;
  } mtl_push_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } mtl_pop_t;

endpackage

FILE: design/morton_index_to_linear.sv
// Top level of the Morton index deswizzle block: config registers, front end,
// queue and back end. Depends on mtl_pkg, mtl_front, mtl_queue, mtl_back.
//
// One request per clock cycle, sustained without a gap. A request accepted at
// a clock edge (start high, busy low) gives its result with valid_o high once it
// has passed the front register, queue, deinterleave stage and the
// multiply-add output register. The back end drains the queue every
// cycle and the receiver takes each result in the cycle it is shown, so busy
// stays low. Write tex_width and tex_height only while no request is in
// flight; both reset to one.
module morton_index_to_linear #(
  parameter int unsigned DIM_BITS = mtl_pkg::DIM_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mtl_pkg::IDX_W-1:0] swizzled_index_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [mtl_pkg::REG_W-1:0] cfg_wdata_i,
  output logic                      valid_o,
  output logic [mtl_pkg::LIN_W-1:0] linear_index_o,
  output logic [mtl_pkg::CRD_W-1:0] column_o,
  output logic [mtl_pkg::CRD_W-1:0] row_o
);
  import mtl_pkg::*;

  logic [REG_W-1:0] tex_width_q, tex_height_q;
  logic             f_push;
  mtl_item_t        f_item, q_item;
  mtl_push_t        push_st;
  mtl_pop_t         pop_st;
  logic             b_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= REG_W'(1);
      tex_height_q <= REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEX_WIDTH:  tex_width_q  <= cfg_wdata_i;
        REG_TEX_HEIGHT: tex_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mtl_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .swizzled_index_i (swizzled_index_i),
    .tex_width_i      (tex_width_q),
    .tex_height_i     (tex_height_q),
    .q_full_i         (push_st.full),
    .q_push_o         (f_push),
    .q_item_o         (f_item)
  );

  mtl_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (f_push),
    .item_i    (f_item),
    .pop_i     (b_pop),
    .item_o    (q_item),
    .push_st_o (push_st),
    .pop_st_o  (pop_st)
  );

  mtl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (pop_st.empty),
    .q_item_i       (q_item),
    .q_pop_o        (b_pop),
    .tex_width_i    (tex_width_q),
    .valid_o        (valid_o),
    .linear_index_o (linear_index_o),
    .column_o       (column_o),
    .row_o          (row_o)
  );

  a_accept_to_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 valid_o
  ) else $error("accepted request gave no result");

  a_result_has_request: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 4)
  ) else $error("result without request");

  a_queue_never_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop_st.pop |-> !push_st.full
  ) else $error("queue full while draining");

  a_push_has_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    push_st.push |-> !push_st.full
  ) else $error("request pushed into a full queue");

endmodule

FILE: design/mtl_front.sv
// Front end: accepts a request, counts the column and row bit budgets.
// Depends on mtl_pkg.
module mtl_front #(
  parameter int unsigned DIM_BITS = mtl_pkg::DIM_BITS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [mtl_pkg::IDX_W-1:0] swizzled_index_i,
  input  logic [mtl_pkg::REG_W-1:0] tex_width_i,
  input  logic [mtl_pkg::REG_W-1:0] tex_height_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output mtl_pkg::mtl_item_t       q_item_o
);
  import mtl_pkg::*;

  logic      valid_q, valid_d;
  mtl_item_t item_q, item_d;
  logic      accept;

  function automatic logic [CNT_W-1:0] dim_bits(input logic [REG_W-1:0] size);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 1; i < REG_W; i++) begin
      if (size[i]) begin
        n = CNT_W'(i);
      end
    end
    if (n > CNT_W'(DIM_BITS)) begin
      n = CNT_W'(DIM_BITS);
    end
    return n;
  endfunction

  assign busy     = valid_q && q_full_i;
  assign accept   = start && !busy;
  assign q_push_o = valid_q && !q_full_i;
  assign q_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d     = 1'b1;
      item_d.idx  = swizzled_index_i;
      item_d.nx   = dim_bits(tex_width_i);
      item_d.ny   = dim_bits(tex_height_i);
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

FILE: design/mtl_queue.sv
// Short queue between front end and back end.
// Depends on mtl_pkg.
module mtl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mtl_pkg::mtl_item_t  item_i,
  input  logic                pop_i,
  output mtl_pkg::mtl_item_t  item_o,
  output mtl_pkg::mtl_push_t  push_st_o,
  output mtl_pkg::mtl_pop_t   pop_st_o
);
  import mtl_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  mtl_item_t        mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_st_o.push  = push_i;
  assign push_st_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign pop_st_o.pop    = pop_i;
  assign pop_st_o.empty  = (cnt_q == '0);
  assign do_push = push_i && !push_st_o.full;
  assign do_pop  = pop_i && !pop_st_o.empty;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: design/mtl_back.sv
// Back end: deinterleaves the index bits, then forms row * width + column.
// Depends on mtl_pkg.
module mtl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  mtl_pkg::mtl_item_t        q_item_i,
  output logic                      q_pop_o,
  input  logic [mtl_pkg::REG_W-1:0] tex_width_i,
  output logic                      valid_o,
  output logic [mtl_pkg::LIN_W-1:0] linear_index_o,
  output logic [mtl_pkg::CRD_W-1:0] column_o,
  output logic [mtl_pkg::CRD_W-1:0] row_o
);
  import mtl_pkg::*;

  localparam int unsigned PosW = $clog2(IDX_W);
  localparam int unsigned ProdW = CRD_W + REG_W;

  logic             a_valid_q;
  logic [CRD_W-1:0] a_col_q, a_col_d;
  logic [CRD_W-1:0] a_row_q, a_row_d;
  logic             out_valid_q;
  logic [LIN_W-1:0] lin_q, lin_d;
  logic [CRD_W-1:0] col_q, row_q;
  logic [ProdW-1:0] prod;

  assign q_pop_o = !q_empty_i;

  always_comb begin
    a_col_d = '0;
    a_row_d = '0;
    for (int k = 0; k < CRD_W; k++) begin
      if (CNT_W'(k) < q_item_i.nx) begin
        if (CNT_W'(k) < q_item_i.ny) begin
          a_col_d[k] = q_item_i.idx[PosW'(2 * k)];
        end else begin
          a_col_d[k] = q_item_i.idx[PosW'(q_item_i.ny) + PosW'(k)];
        end
      end
      if (CNT_W'(k) < q_item_i.ny) begin
        if (CNT_W'(k) < q_item_i.nx) begin
          a_row_d[k] = q_item_i.idx[PosW'(2 * k + 1)];
        end else begin
          a_row_d[k] = q_item_i.idx[PosW'(q_item_i.nx) + PosW'(k)];
        end
      end
    end
  end

  assign prod  = ProdW'(a_row_q) * ProdW'(tex_width_i);
  assign lin_d = prod[LIN_W-1:0] + LIN_W'(a_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= q_pop_o;
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_col_q <= a_col_d;
    a_row_q <= a_row_d;
    lin_q   <= lin_d;
    col_q   <= a_col_q;
    row_q   <= a_row_q;
  end

  assign valid_o        = out_valid_q;
  assign linear_index_o = lin_q;
  assign column_o       = col_q;
  assign row_o          = row_q;

endmodule
